// ===== rtl/core/kis_pkg.sv =====
package kis_pkg;

  localparam int MaxKeys  = 64;
  localparam int TimeBits = 32;
  localparam int FracBits = 16;

  localparam int IdxW    = $clog2(MaxKeys);
  localparam int CntW    = IdxW + 1;
  localparam int CountW  = 7;
  localparam int CmdW    = 2;
  localparam int FracW   = FracBits + 1;
  localparam int DivCntW = $clog2(FracBits);

  localparam logic [FracW-1:0] FracOne = FracW'(1) << FracBits;

  typedef enum logic [CmdW-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_PLAIN  = 2'd1,
    CMD_CACHED = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_WRITE,
    OP_LOAD,
    OP_INIT_ZERO,
    OP_INIT_HINT2,
    OP_SEARCH_STEP,
    OP_FIX,
    OP_SEG_HINT,
    OP_SEG_HINT1,
    OP_LATCH_P0,
    OP_LATCH_P1,
    OP_DIV_PREP,
    OP_DIV_STEP,
    OP_RES_ZERO,
    OP_RES_LAST,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [3:0] {
    RD_ZERO,
    RD_LAST,
    RD_HINT,
    RD_HINT1,
    RD_HINT2,
    RD_PROBE,
    RD_CUR,
    RD_SEG,
    RD_SEG1
  } rd_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P_K0,
    ST_P_K0E,
    ST_P_KL,
    ST_C_START,
    ST_C_KH,
    ST_C_K0,
    ST_C_KL,
    ST_C_K1,
    ST_C_K2,
    ST_S_ISSUE,
    ST_S_EVAL,
    ST_S_FIX,
    ST_F_RD0,
    ST_F_RD1,
    ST_F_RD2,
    ST_F_PREP,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    dp_op_e  op;
    rd_sel_e rd;
  } kis_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic hint_ge_n;
    logic hint1_ge_n;
    logic hint2_ge_n;
    logic t_lt_rd;
    logic t_le_rd;
    logic cnt_zero;
    logic div_trivial;
    logic div_last;
    logic out_free;
  } kis_stat_t;

endpackage

// ===== rtl/core/kis_ctrl.sv =====
module kis_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [kis_pkg::CmdW-1:0] cmd_i,
  input  kis_pkg::kis_stat_t      stat_i,
  output logic                    in_stall_o,
  output kis_pkg::kis_cmd_t       ctl_o
);

  kis_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kis_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      kis_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            kis_pkg::CMD_PLAIN:  state_d = kis_pkg::ST_P_K0;
            kis_pkg::CMD_CACHED: state_d = kis_pkg::ST_C_START;
            default:             state_d = kis_pkg::ST_IDLE;
          endcase
        end
      end
      kis_pkg::ST_P_K0: begin
        state_d = stat_i.n_lt2 ? kis_pkg::ST_FINISH : kis_pkg::ST_P_K0E;
      end
      kis_pkg::ST_P_K0E: begin
        state_d = stat_i.t_le_rd ? kis_pkg::ST_FINISH : kis_pkg::ST_P_KL;
      end
      kis_pkg::ST_P_KL: begin
        state_d = !stat_i.t_lt_rd ? kis_pkg::ST_FINISH : kis_pkg::ST_S_ISSUE;
      end
      kis_pkg::ST_C_START: begin
        state_d = stat_i.hint_ge_n ? kis_pkg::ST_P_K0 : kis_pkg::ST_C_KH;
      end
      kis_pkg::ST_C_KH: begin
        if (stat_i.t_lt_rd) begin
          state_d = kis_pkg::ST_P_K0;
        end else if (stat_i.n_lt2) begin
          state_d = kis_pkg::ST_FINISH;
        end else begin
          state_d = kis_pkg::ST_C_K0;
        end
      end
      kis_pkg::ST_C_K0: begin
        state_d = stat_i.t_le_rd ? kis_pkg::ST_FINISH : kis_pkg::ST_C_KL;
      end
      kis_pkg::ST_C_KL: begin
        if (!stat_i.t_lt_rd) begin
          state_d = kis_pkg::ST_FINISH;
        end else if (stat_i.hint1_ge_n) begin
          state_d = kis_pkg::ST_S_ISSUE;
        end else begin
          state_d = kis_pkg::ST_C_K1;
        end
      end
      kis_pkg::ST_C_K1: begin
        if (stat_i.t_le_rd) begin
          state_d = kis_pkg::ST_F_RD0;
        end else if (stat_i.hint2_ge_n) begin
          state_d = kis_pkg::ST_S_ISSUE;
        end else begin
          state_d = kis_pkg::ST_C_K2;
        end
      end
      kis_pkg::ST_C_K2: begin
        state_d = stat_i.t_le_rd ? kis_pkg::ST_F_RD0 : kis_pkg::ST_S_ISSUE;
      end
      kis_pkg::ST_S_ISSUE: begin
        state_d = stat_i.cnt_zero ? kis_pkg::ST_S_FIX : kis_pkg::ST_S_EVAL;
      end
      kis_pkg::ST_S_EVAL: state_d = kis_pkg::ST_S_ISSUE;
      kis_pkg::ST_S_FIX:  state_d = kis_pkg::ST_F_RD0;
      kis_pkg::ST_F_RD0:  state_d = kis_pkg::ST_F_RD1;
      kis_pkg::ST_F_RD1:  state_d = kis_pkg::ST_F_RD2;
      kis_pkg::ST_F_RD2:  state_d = kis_pkg::ST_F_PREP;
      kis_pkg::ST_F_PREP: begin
        state_d = stat_i.div_trivial ? kis_pkg::ST_FINISH : kis_pkg::ST_DIV;
      end
      kis_pkg::ST_DIV: begin
        if (stat_i.div_last) begin
          state_d = kis_pkg::ST_FINISH;
        end
      end
      kis_pkg::ST_FINISH: begin
        if (stat_i.out_free) begin
          state_d = kis_pkg::ST_IDLE;
        end
      end
      default: state_d = kis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.op   = kis_pkg::OP_IDLE;
    ctl_o.rd   = kis_pkg::RD_ZERO;
    in_stall_o = 1'b1;
    case (state_q)
      kis_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (cmd_i)
            kis_pkg::CMD_WRITE:  ctl_o.op = kis_pkg::OP_WRITE;
            kis_pkg::CMD_PLAIN:  ctl_o.op = kis_pkg::OP_LOAD;
            kis_pkg::CMD_CACHED: ctl_o.op = kis_pkg::OP_LOAD;
            default:             ctl_o.op = kis_pkg::OP_IDLE;
          endcase
        end
      end
      kis_pkg::ST_P_K0: begin
        if (stat_i.n_lt2) begin
          ctl_o.op = kis_pkg::OP_RES_ZERO;
        end else begin
          ctl_o.rd = kis_pkg::RD_ZERO;
        end
      end
      kis_pkg::ST_P_K0E: begin
        if (stat_i.t_le_rd) begin
          ctl_o.op = kis_pkg::OP_RES_ZERO;
        end else begin
          ctl_o.rd = kis_pkg::RD_LAST;
        end
      end
      kis_pkg::ST_P_KL: begin
        ctl_o.op = !stat_i.t_lt_rd ? kis_pkg::OP_RES_LAST : kis_pkg::OP_INIT_ZERO;
      end
      kis_pkg::ST_C_START: ctl_o.rd = kis_pkg::RD_HINT;
      kis_pkg::ST_C_KH: begin
        if (!stat_i.t_lt_rd && stat_i.n_lt2) begin
          ctl_o.op = kis_pkg::OP_RES_ZERO;
        end
        ctl_o.rd = kis_pkg::RD_ZERO;
      end
      kis_pkg::ST_C_K0: begin
        if (stat_i.t_le_rd) begin
          ctl_o.op = kis_pkg::OP_RES_ZERO;
        end else begin
          ctl_o.rd = kis_pkg::RD_LAST;
        end
      end
      kis_pkg::ST_C_KL: begin
        if (!stat_i.t_lt_rd) begin
          ctl_o.op = kis_pkg::OP_RES_LAST;
        end else if (stat_i.hint1_ge_n) begin
          ctl_o.op = kis_pkg::OP_INIT_ZERO;
        end else begin
          ctl_o.rd = kis_pkg::RD_HINT1;
        end
      end
      kis_pkg::ST_C_K1: begin
        if (stat_i.t_le_rd) begin
          ctl_o.op = kis_pkg::OP_SEG_HINT;
        end else if (stat_i.hint2_ge_n) begin
          ctl_o.op = kis_pkg::OP_INIT_ZERO;
        end else begin
          ctl_o.rd = kis_pkg::RD_HINT2;
        end
      end
      kis_pkg::ST_C_K2: begin
        ctl_o.op = stat_i.t_le_rd ? kis_pkg::OP_SEG_HINT1 : kis_pkg::OP_INIT_HINT2;
      end
      kis_pkg::ST_S_ISSUE: begin
        ctl_o.rd = stat_i.cnt_zero ? kis_pkg::RD_CUR : kis_pkg::RD_PROBE;
      end
      kis_pkg::ST_S_EVAL: ctl_o.op = kis_pkg::OP_SEARCH_STEP;
      kis_pkg::ST_S_FIX:  ctl_o.op = kis_pkg::OP_FIX;
      kis_pkg::ST_F_RD0:  ctl_o.rd = kis_pkg::RD_SEG;
      kis_pkg::ST_F_RD1: begin
        ctl_o.op = kis_pkg::OP_LATCH_P0;
        ctl_o.rd = kis_pkg::RD_SEG1;
      end
      kis_pkg::ST_F_RD2:  ctl_o.op = kis_pkg::OP_LATCH_P1;
      kis_pkg::ST_F_PREP: ctl_o.op = kis_pkg::OP_DIV_PREP;
      kis_pkg::ST_DIV:    ctl_o.op = kis_pkg::OP_DIV_STEP;
      kis_pkg::ST_FINISH: begin
        if (stat_i.out_free) begin
          ctl_o.op = kis_pkg::OP_FINISH;
        end
      end
      default: ctl_o.op = kis_pkg::OP_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/kis_dpath.sv =====
module kis_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kis_pkg::CountW-1:0]        cfg_wdata_i,
  input  logic [kis_pkg::CmdW-1:0]          cmd_i,
  input  logic [kis_pkg::IdxW-1:0]          key_slot_i,
  input  logic signed [kis_pkg::TimeBits-1:0] time_value_i,
  input  logic                              out_stall_i,
  input  kis_pkg::kis_cmd_t                 ctl_i,
  output kis_pkg::kis_stat_t                stat_o,
  output logic                              out_valid_o,
  output logic [kis_pkg::IdxW-1:0]          segment_index_o,
  output logic [kis_pkg::FracW-1:0]         fraction_o
);

  localparam int TW = kis_pkg::TimeBits;
  localparam int CW = kis_pkg::CntW;
  localparam int IW = kis_pkg::IdxW;
  localparam int FB = kis_pkg::FracBits;

  logic [TW-1:0] mem_q [kis_pkg::MaxKeys];
  logic [TW-1:0] rdata_q, t_q, p0_q, p1_q, rem_q, den_q;
  logic [FB-1:0] quo_q;
  logic [kis_pkg::DivCntW-1:0] div_cnt_q;
  logic [CW-1:0] lo_q, cnt_q, first_q;
  logic [IW-1:0] res_idx_q, out_idx_q, hint_q;
  logic [kis_pkg::FracW-1:0] res_frac_q, out_frac_q;
  logic cached_q, out_valid_q;
  logic [kis_pkg::CountW-1:0] key_count_q;

  logic [TW-1:0] t_in, num, den;
  logic [TW:0] rem2, rem_nx;
  logic [FB-1:0] quo_nx;
  logic [CW-1:0] n_c, n_m1, n_m2, hint_ext, hint1, hint2, step, probe, cur, cur_dec, fix_idx;
  logic [IW-1:0] rd_addr;
  logic ge, frac_zero, frac_one, out_free;

  assign t_in = {~time_value_i[TW-1], time_value_i[TW-2:0]};

  assign n_c = (int'(key_count_q) > kis_pkg::MaxKeys) ? CW'(kis_pkg::MaxKeys)
                                                      : CW'(key_count_q);
  assign n_m1     = n_c - CW'(1);
  assign n_m2     = n_c - CW'(2);
  assign hint_ext = {1'b0, hint_q};
  assign hint1    = hint_ext + CW'(1);
  assign hint2    = hint_ext + CW'(2);
  assign step     = cnt_q >> 1;
  assign probe    = lo_q + step;
  assign cur      = (lo_q >= n_c) ? n_m1 : lo_q;
  assign cur_dec  = (rdata_q > t_q && cur != first_q) ? cur - CW'(1) : cur;
  assign fix_idx  = (cur_dec + CW'(1) >= n_c) ? n_m2 : cur_dec;

  assign num       = t_q - p0_q;
  assign den       = p1_q - p0_q;
  assign frac_zero = (p1_q <= p0_q) || (t_q < p0_q);
  assign frac_one  = num >= den;

  assign rem2   = {rem_q, 1'b0};
  assign ge     = rem2 >= {1'b0, den_q};
  assign rem_nx = ge ? rem2 - {1'b0, den_q} : rem2;
  assign quo_nx = {quo_q[FB-2:0], ge};

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    case (ctl_i.rd)
      kis_pkg::RD_ZERO:  rd_addr = '0;
      kis_pkg::RD_LAST:  rd_addr = n_m1[IW-1:0];
      kis_pkg::RD_HINT:  rd_addr = hint_q;
      kis_pkg::RD_HINT1: rd_addr = hint1[IW-1:0];
      kis_pkg::RD_HINT2: rd_addr = hint2[IW-1:0];
      kis_pkg::RD_PROBE: rd_addr = probe[IW-1:0];
      kis_pkg::RD_CUR:   rd_addr = cur[IW-1:0];
      kis_pkg::RD_SEG:   rd_addr = res_idx_q;
      kis_pkg::RD_SEG1:  rd_addr = res_idx_q + IW'(1);
      default:           rd_addr = '0;
    endcase
  end

  always_comb begin
    stat_o.n_lt2       = n_c < CW'(2);
    stat_o.hint_ge_n   = hint_ext >= n_c;
    stat_o.hint1_ge_n  = hint1 >= n_c;
    stat_o.hint2_ge_n  = hint2 >= n_c;
    stat_o.t_lt_rd     = t_q < rdata_q;
    stat_o.t_le_rd     = t_q <= rdata_q;
    stat_o.cnt_zero    = cnt_q == '0;
    stat_o.div_trivial = frac_zero || frac_one;
    stat_o.div_last    = div_cnt_q == kis_pkg::DivCntW'(FB - 1);
    stat_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == kis_pkg::OP_WRITE) begin
      mem_q[key_slot_i] <= t_in;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_count_q <= cfg_wdata_i;
      end
      if (ctl_i.op == kis_pkg::OP_FINISH) begin
        out_valid_q <= 1'b1;
        if (cached_q) begin
          hint_q <= res_idx_q;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      kis_pkg::OP_LOAD: begin
        t_q      <= t_in;
        cached_q <= cmd_i == kis_pkg::CMD_CACHED;
      end
      kis_pkg::OP_INIT_ZERO: begin
        lo_q    <= '0;
        first_q <= '0;
        cnt_q   <= n_c;
      end
      kis_pkg::OP_INIT_HINT2: begin
        lo_q    <= hint2;
        first_q <= hint2;
        cnt_q   <= n_c - hint2;
      end
      kis_pkg::OP_SEARCH_STEP: begin
        if (rdata_q < t_q) begin
          lo_q  <= probe + CW'(1);
          cnt_q <= cnt_q - step - CW'(1);
        end else begin
          cnt_q <= step;
        end
      end
      kis_pkg::OP_FIX:       res_idx_q <= fix_idx[IW-1:0];
      kis_pkg::OP_SEG_HINT:  res_idx_q <= hint_q;
      kis_pkg::OP_SEG_HINT1: res_idx_q <= hint1[IW-1:0];
      kis_pkg::OP_LATCH_P0:  p0_q <= rdata_q;
      kis_pkg::OP_LATCH_P1:  p1_q <= rdata_q;
      kis_pkg::OP_DIV_PREP: begin
        rem_q      <= num;
        den_q      <= den;
        quo_q      <= '0;
        div_cnt_q  <= '0;
        res_frac_q <= (!frac_zero && frac_one) ? kis_pkg::FracOne : '0;
      end
      kis_pkg::OP_DIV_STEP: begin
        rem_q     <= rem_nx[TW-1:0];
        quo_q     <= quo_nx;
        div_cnt_q <= div_cnt_q + kis_pkg::DivCntW'(1);
        res_frac_q <= {1'b0, quo_nx};
      end
      kis_pkg::OP_RES_ZERO: begin
        res_idx_q  <= '0;
        res_frac_q <= '0;
      end
      kis_pkg::OP_RES_LAST: begin
        res_idx_q  <= n_m1[IW-1:0];
        res_frac_q <= '0;
      end
      kis_pkg::OP_FINISH: begin
        out_idx_q  <= res_idx_q;
        out_frac_q <= res_frac_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign segment_index_o = out_idx_q;
  assign fraction_o      = out_frac_q;

endmodule

// ===== rtl/core/keyframe_interval_search_unit.sv =====
// Channel   Signals                                   Direction
// input     in_valid_i, in_stall_o, cmd_i,            in
//           key_slot_i, time_value_i
// output    out_valid_o, out_stall_i,                 out
//           segment_index_o, fraction_o
// config    cfg_we_i, cfg_wdata_i (key_count)         in
//
// A key write leaves the unit idle for the next transaction. The key table
// has one registered read port, so a binary-search probe is issued and then
// evaluated; the fraction comes from a restoring divider, one bit a cycle.
// Reset is asynchronous, active low; the key table is not cleared.
// A finished result sits in the output register; the next transaction is
// taken while it waits, and the following result holds until it is taken.
module keyframe_interval_search_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kis_pkg::CountW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [kis_pkg::CmdW-1:0]            cmd_i,
  input  logic [kis_pkg::IdxW-1:0]            key_slot_i,
  input  logic signed [kis_pkg::TimeBits-1:0] time_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [kis_pkg::IdxW-1:0]            segment_index_o,
  output logic [kis_pkg::FracW-1:0]           fraction_o
);

  kis_pkg::kis_cmd_t  ctl;
  kis_pkg::kis_stat_t stat;

  kis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl)
  );

  kis_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd_i),
    .key_slot_i      (key_slot_i),
    .time_value_i    (time_value_i),
    .out_stall_i     (out_stall_i),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .segment_index_o (segment_index_o),
    .fraction_o      (fraction_o)
  );

endmodule

// ===== rtl/core/kis_chk.sv =====
module kis_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic [kis_pkg::CountW-1:0]          cfg_wdata_i,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [kis_pkg::CmdW-1:0]            cmd_i,
  input logic [kis_pkg::IdxW-1:0]            key_slot_i,
  input logic signed [kis_pkg::TimeBits-1:0] time_value_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [kis_pkg::IdxW-1:0]            segment_index_o,
  input logic [kis_pkg::FracW-1:0]           fraction_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(segment_index_o) && $stable(fraction_o))
    else $error("stalled result changed");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fraction_o <= kis_pkg::FracOne)
    else $error("fraction above one");

  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cmd_i == kis_pkg::CMD_WRITE |=> !in_stall_o)
    else $error("key write did not complete in one cycle");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cmd_i == kis_pkg::CMD_PLAIN || cmd_i == kis_pkg::CMD_CACHED)
      |=> in_stall_o)
    else $error("query transaction did not occupy the unit");

endmodule

bind keyframe_interval_search_unit kis_chk u_kis_chk (.*);
